### src/telemetry_frame_parser_crc_check_unit_defines.svh
// Assertion helpers for the telemetry frame parser.
`ifndef TELEMETRY_FRAME_PARSER_CRC_CHECK_UNIT_DEFINES_SVH
`define TELEMETRY_FRAME_PARSER_CRC_CHECK_UNIT_DEFINES_SVH

// Check a same-cycle implication outside reset.
`define TFP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tfp: implication check failed");

// Check a next-cycle implication, reset included.
`define TFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tfp: next-cycle check failed");

`endif

### src/tfp_pkg.sv
`default_nettype none
package tfp_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 255;
  localparam int unsigned MIN_LEN             = 31;
  localparam int unsigned FULL_LEN            = 50;
  localparam int unsigned OQ_DEPTH            = 4;
  localparam logic [15:0] CRC_INIT            = 16'hFFFF;
  localparam logic [15:0] CRC_POLY            = 16'h1021;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PARSE = 2'd1,
    ST_CRC   = 2'd2
  } status_t;

  typedef struct packed {
    logic [4:0]  field_id;
    logic [31:0] field_value;
    logic        is_status;
    status_t     frame_status;
    logic        has_previous;
    logic        run_last;
  } result_t;

  typedef struct packed {
    logic    en0;
    logic    en1;
    result_t r0;
    result_t r1;
  } push_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [4:0] pos_field(input logic [5:0] p);
    logic [4:0] id;
    if      (p <= 6'd0)  id = 5'd0;
    else if (p <= 6'd1)  id = 5'd1;
    else if (p <= 6'd5)  id = 5'd2;
    else if (p <= 6'd6)  id = 5'd3;
    else if (p <= 6'd7)  id = 5'd4;
    else if (p <= 6'd8)  id = 5'd5;
    else if (p <= 6'd9)  id = 5'd6;
    else if (p <= 6'd11) id = 5'd7;
    else if (p <= 6'd12) id = 5'd8;
    else if (p <= 6'd13) id = 5'd9;
    else if (p <= 6'd15) id = 5'd10;
    else if (p <= 6'd17) id = 5'd11;
    else if (p <= 6'd19) id = 5'd12;
    else if (p <= 6'd23) id = 5'd13;
    else if (p <= 6'd25) id = 5'd14;
    else if (p <= 6'd26) id = 5'd15;
    else if (p <= 6'd27) id = 5'd16;
    else if (p <= 6'd28) id = 5'd17;
    else if (p <= 6'd32) id = 5'd18;
    else if (p <= 6'd34) id = 5'd19;
    else if (p <= 6'd36) id = 5'd20;
    else if (p <= 6'd38) id = 5'd21;
    else if (p <= 6'd42) id = 5'd22;
    else if (p <= 6'd44) id = 5'd23;
    else if (p <= 6'd45) id = 5'd24;
    else if (p <= 6'd46) id = 5'd25;
    else                 id = 5'd26;
    return id;
  endfunction

  function automatic logic pos_last(input logic [5:0] p);
    logic l;
    case (p)
      6'd0, 6'd1, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd11, 6'd12, 6'd13,
      6'd15, 6'd17, 6'd19, 6'd23, 6'd25, 6'd26, 6'd27, 6'd28,
      6'd32, 6'd34, 6'd36, 6'd38, 6'd42, 6'd44, 6'd45, 6'd46, 6'd47: l = 1'b1;
      default: l = 1'b0;
    endcase
    return l;
  endfunction

  function automatic logic [4:0] field_shift(input logic [4:0] id);
    logic [4:0] sh;
    case (id)
      5'd2, 5'd13, 5'd18, 5'd22: sh = 5'd0;
      5'd7, 5'd10, 5'd11, 5'd12, 5'd14, 5'd19, 5'd20, 5'd21, 5'd23: sh = 5'd16;
      default: sh = 5'd24;
    endcase
    return sh;
  endfunction

endpackage
`default_nettype wire

### src/tfp_core.sv
`default_nettype none
module tfp_core #(
  parameter int unsigned MAX_FRAME_BYTES = tfp_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_valid,
  output logic               s_ready,
  input  wire logic [7:0]    s_byte,
  input  wire logic          s_eof,
  input  wire logic          room,
  output tfp_pkg::push_t     push
);
  import tfp_pkg::*;

  localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);

  logic          in_valid;
  logic [7:0]    in_byte;
  logic          in_eof;
  logic          consume;

  logic [15:0]   crc;
  logic [CW-1:0] count;
  logic [7:0]    held0;
  logic [7:0]    held1;
  logic [31:0]   accum;

  logic          has_commit;
  logic          in_payload;
  logic [CW-1:0] p_full;
  logic [5:0]    p;
  logic [4:0]    fid;
  logic          field_fire;
  logic [15:0]   crc_next;
  logic [31:0]   accum_next;
  logic [CW-1:0] count_next;
  logic [15:0]   incoming;
  status_t       status;
  result_t       field_res;
  result_t       status_res;

  assign consume = in_valid && room;
  assign s_ready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_valid && s_ready) begin
      in_valid <= 1'b1;
    end else if (consume) begin
      in_valid <= 1'b0;
    end
    if (s_valid && s_ready) begin
      in_byte <= s_byte;
      in_eof  <= s_eof;
    end
  end

  always_comb begin
    has_commit = count >= CW'(2);
    in_payload = has_commit && (count < CW'(FULL_LEN));
    p_full     = count - CW'(2);
    p          = p_full[5:0];
    fid        = pos_field(p);
    field_fire = in_payload && pos_last(p);
    crc_next   = has_commit ? crc_byte(crc, held0) : crc;
    accum_next = in_payload ? {held0, accum[31:8]} : accum;
    count_next = (count < CW'(MAX_FRAME_BYTES)) ? count + CW'(1) : count;
    incoming   = {in_byte, held1};

    if (count_next < CW'(MIN_LEN)) begin
      status = ST_PARSE;
    end else if (incoming != crc_next) begin
      status = ST_CRC;
    end else if ((count_next > CW'(MIN_LEN)) && (count_next < CW'(FULL_LEN))) begin
      status = ST_PARSE;
    end else begin
      status = ST_OK;
    end

    field_res.field_id     = fid;
    field_res.field_value  = accum_next >> field_shift(fid);
    field_res.is_status    = 1'b0;
    field_res.frame_status = ST_OK;
    field_res.has_previous = 1'b0;
    field_res.run_last     = !in_eof;

    status_res.field_id     = 5'd0;
    status_res.field_value  = 32'd0;
    status_res.is_status    = 1'b1;
    status_res.frame_status = status;
    status_res.has_previous = count_next > CW'(MIN_LEN);
    status_res.run_last     = 1'b1;

    push.en0 = consume && (field_fire || in_eof);
    push.en1 = consume && field_fire && in_eof;
    push.r0  = field_fire ? field_res : status_res;
    push.r1  = status_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc   <= CRC_INIT;
      count <= '0;
      held0 <= 8'd0;
      held1 <= 8'd0;
      accum <= 32'd0;
    end else if (consume) begin
      if (in_eof) begin
        crc   <= CRC_INIT;
        count <= '0;
        held0 <= 8'd0;
        held1 <= 8'd0;
        accum <= 32'd0;
      end else begin
        crc   <= crc_next;
        count <= count_next;
        held0 <= held1;
        held1 <= in_byte;
        accum <= accum_next;
      end
    end
  end

endmodule
`default_nettype wire

### src/tfp_outq.sv
`default_nettype none
module tfp_outq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tfp_pkg::push_t push,
  output logic                room,
  output logic                valid,
  input  wire logic           ready,
  output tfp_pkg::result_t    head
);
  import tfp_pkg::*;

  localparam int unsigned AW = $clog2(OQ_DEPTH);
  localparam int unsigned NW = $clog2(OQ_DEPTH + 1);

  result_t       mem [OQ_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic [NW-1:0] count_next;
  logic [AW-1:0] wr_ptr_next;
  logic          pop;

  assign valid = count != '0;
  assign pop   = valid && ready;
  assign room  = count <= NW'(OQ_DEPTH - 2);
  assign head  = mem[rd_ptr];

  always_comb begin
    count_next  = count + NW'(push.en0) + NW'(push.en1) - NW'(pop);
    wr_ptr_next = wr_ptr + AW'(push.en0) + AW'(push.en1);
  end

  always_ff @(posedge clk) begin
    if (push.en0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.en1) begin
      mem[wr_ptr + AW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
    end
  end

endmodule
`default_nettype wire

### src/telemetry_frame_parser_crc_check_unit.sv
// Channel | Direction | tdata (low bit first)                          | tuser     | tlast
// s_      | in        | byte_in[7:0]                                   | -         | end_of_frame
// m_      | out       | field_id[4:0] field_value[36:5]                | is_status | run_last
//         |           | frame_status[38:37] has_previous[39]           |           |
// One byte per unstalled cycle: the input register feeds one pass of CRC and field logic.
// A byte gives no beat, one field beat, one status beat, or both at frame end.
// Results pass through a four-entry output queue; input stalls when fewer
// than two entries are free.
// rst is synchronous: frame state returns to CRC 0xFFFF and count zero.
`default_nettype none
module telemetry_frame_parser_crc_check_unit #(
  parameter int unsigned MAX_FRAME_BYTES = tfp_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // byte_in
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // field_id, field_value, frame_status, has_previous
  output logic             m_tuser,  // is_status
  output logic             m_tlast
);
  import tfp_pkg::*;

  push_t   push;
  logic    room;
  result_t head;

  tfp_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .s_valid(s_tvalid),
    .s_ready(s_tready),
    .s_byte (s_tdata),
    .s_eof  (s_tlast),
    .room   (room),
    .push   (push)
  );

  tfp_outq u_outq (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .valid(m_tvalid),
    .ready(m_tready),
    .head (head)
  );

  assign m_tdata = {head.has_previous, head.frame_status, head.field_value, head.field_id};
  assign m_tuser = head.is_status;
  assign m_tlast = head.run_last;

endmodule
`default_nettype wire

### src/tfp_checker.sv
`default_nettype none
`include "telemetry_frame_parser_crc_check_unit_defines.svh"
module tfp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic        m_tuser,
  input wire logic        m_tlast
);

  `TFP_ASSERT_IMPLY(a_status_last, m_tvalid && m_tuser, m_tlast)
  `TFP_ASSERT_IMPLY(a_status_clean, m_tvalid && m_tuser, m_tdata[36:0] == 37'd0)
  `TFP_ASSERT_IMPLY(a_field_clean, m_tvalid && !m_tuser, (m_tdata[39:37] == 3'd0) && (m_tdata[4:0] <= 5'd26))
  `TFP_ASSERT_NEXT(a_reset_empty, rst, !m_tvalid)
  `TFP_ASSERT_IMPLY(a_hold, $past(m_tvalid && !m_tready && !rst), m_tvalid)

endmodule

bind telemetry_frame_parser_crc_check_unit tfp_checker u_tfp_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);
`default_nettype wire

### test/tb_telemetry_frame_parser_crc_check_unit_checker.sv
`timescale 1ns / 1ps

module tb_telemetry_frame_parser_crc_check_unit_checker
  import tfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // byte_in
  input  logic        s_tlast,   // end_of_frame
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // field_id, field_value, frame_status, has_previous
  input  logic        m_tuser,   // is_status
  input  logic        m_tlast,   // run_last
  output int          mismatches,
  output int          pending
);

  localparam int unsigned PAYLOAD_BYTES = 48;
  localparam int unsigned NUM_FIELDS    = 27;
  localparam int unsigned REPORT_LIMIT  = 10;

  localparam int unsigned FIELD_LEN [NUM_FIELDS] = '{
    1, 1, 4, 1, 1, 1, 1, 2, 1, 1,
    2, 2, 2, 4, 2, 1, 1, 1,
    4,
    2, 2, 2, 4, 2, 1, 1, 1
  };

  logic [4:0]  slot_field [PAYLOAD_BYTES];
  logic        slot_closes [PAYLOAD_BYTES];

  logic [15:0] crc_acc;
  int unsigned frame_len;
  logic [7:0]  tail_lo;
  logic [7:0]  tail_hi;
  logic [31:0] field_shift;
  result_t     field_results_q[$];

  initial begin
    int unsigned slot;
    slot = 0;
    for (int f = 0; f < NUM_FIELDS; f++) begin
      for (int k = 0; k < FIELD_LEN[f]; k++) begin
        slot_field[slot]  = 5'(f);
        slot_closes[slot] = (k == FIELD_LEN[f] - 1);
        slot++;
      end
    end
  end

  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc_in,
                                                 input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  task automatic clear_frame();
    crc_acc     = CRC_INIT;
    frame_len   = 0;
    tail_lo     = 8'h00;
    tail_hi     = 8'h00;
    field_shift = 32'h0;
  endtask

  task automatic predict_byte(input logic [7:0] data, input logic eof);
    result_t     r;
    int unsigned p;
    logic [4:0]  id;
    if (frame_len >= 2) begin
      crc_acc = crc_ccitt_step(crc_acc, tail_lo);
      p = frame_len - 2;
      if (p < PAYLOAD_BYTES) begin
        field_shift = {tail_lo, field_shift[31:8]};
        if (slot_closes[p]) begin
          id            = slot_field[p];
          r             = '0;
          r.field_id    = id;
          r.field_value = field_shift >> (32 - 8 * FIELD_LEN[id]);
          r.frame_status = ST_OK;
          r.run_last    = !eof;
          field_results_q.push_back(r);
        end
      end
    end
    tail_lo = tail_hi;
    tail_hi = data;
    if (frame_len < MAX_FRAME_BYTES_DEF) frame_len++;
    if (eof) begin
      r           = '0;
      r.is_status = 1'b1;
      if (frame_len < MIN_LEN) begin
        r.frame_status = ST_PARSE;
      end else if ({tail_hi, tail_lo} != crc_acc) begin
        r.frame_status = ST_CRC;
      end else if (frame_len > MIN_LEN && frame_len < FULL_LEN) begin
        r.frame_status = ST_PARSE;
      end else begin
        r.frame_status = ST_OK;
      end
      r.has_previous = (frame_len > MIN_LEN);
      r.run_last     = 1'b1;
      field_results_q.push_back(r);
      clear_frame();
    end
  endtask

  task automatic check_beat();
    result_t     want;
    logic [4:0]  got_id;
    logic [31:0] got_value;
    logic [1:0]  got_status;
    logic        got_prev;
    got_id     = m_tdata[4:0];
    got_value  = m_tdata[36:5];
    got_status = m_tdata[38:37];
    got_prev   = m_tdata[39];
    if (field_results_q.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("unexpected beat: id %0d value %h is_status %b status %0d prev %b last %b",
                 got_id, got_value, m_tuser, got_status, got_prev, m_tlast);
    end else begin
      want = field_results_q.pop_front();
      if (want.field_id != got_id || want.field_value != got_value ||
          want.is_status != m_tuser || want.frame_status != got_status ||
          want.has_previous != got_prev || want.run_last != m_tlast) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("mismatch exp: id %0d value %h is_status %b status %0d prev %b last %b",
                   want.field_id, want.field_value, want.is_status, want.frame_status,
                   want.has_previous, want.run_last);
          $display("         got: id %0d value %h is_status %b status %0d prev %b last %b",
                   got_id, got_value, m_tuser, got_status, got_prev, m_tlast);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_frame();
      field_results_q.delete();
      mismatches = 0;
      pending    = 0;
    end else begin
      if (s_tvalid && s_tready) predict_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_beat();
      pending = field_results_q.size();
    end
  end

endmodule

### test/tb_telemetry_frame_parser_crc_check_unit.sv
`timescale 1ns / 1ps

module tb_telemetry_frame_parser_crc_check_unit;
  import tfp_pkg::*;

  localparam int unsigned RANDOM_BEATS = 1250;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 32;

  typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // byte_in
  logic        s_tlast = 1'b0;    // end_of_frame
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;           // field_id, field_value, frame_status, has_previous
  logic        m_tuser;           // is_status
  logic        m_tlast;           // run_last

  int          mismatches;
  int          pending;
  int unsigned beats_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned mode_left = 0;
  logic [7:0]  ready_mask = 8'h01;

  telemetry_frame_parser_crc_check_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  tb_telemetry_frame_parser_crc_check_unit_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      mode_left <= 0;
    end else if (mode_left == 0) begin
      rx_mode    <= rx_mode_t'($urandom_range(0, 3));
      mode_left  <= $urandom_range(40, 300);
      ready_mask <= 8'($urandom_range(1, 255));
      m_tready   <= 1'b1;
    end else begin
      mode_left <= mode_left - 1;
      case (rx_mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default: begin
          m_tready   <= ready_mask[0];
          ready_mask <= {ready_mask[0], ready_mask[7:1]};
        end
      endcase
    end
  end

  function automatic logic [15:0] frame_crc_step(input logic [15:0] crc_in,
                                                 input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  task automatic send_beat(input logic [7:0] data, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 64);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_frame(input int unsigned len, input bit good_crc, input fill_t fill);
    logic [15:0] crc;
    logic [7:0]  data;
    logic [7:0]  flip;
    crc  = CRC_INIT;
    flip = 8'($urandom_range(1, 255));
    for (int unsigned i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: data = 8'h00;
        FILL_ONES: data = 8'hFF;
        default:   data = 8'($urandom_range(0, 255));
      endcase
      if (i + 2 < len) begin
        crc = frame_crc_step(crc, data);
      end else begin
        data = (i + 2 == len) ? crc[7:0] : crc[15:8];
        if (!good_crc && i + 2 == len) data = data ^ flip;
      end
      send_beat(data, i == len - 1);
    end
  endtask

  initial begin
    int unsigned target;
    int unsigned frames;
    int unsigned pick;
    int unsigned fill_pick;
    fill_t       fill;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_frame(1, 1'b1, FILL_ZERO);
    send_frame(1, 1'b1, FILL_ONES);
    send_frame(2, 1'b1, FILL_RANDOM);
    send_frame(3, 1'b1, FILL_ZERO);
    send_frame(17, 1'b0, FILL_ONES);

    target = beats_sent + RANDOM_BEATS;
    frames = 0;
    while (beats_sent < target) begin
      pick      = $urandom_range(0, 99);
      fill_pick = $urandom_range(0, 19);
      fill      = (fill_pick == 0) ? FILL_ZERO : (fill_pick == 1) ? FILL_ONES : FILL_RANDOM;
      if (frames == 2) begin
        send_frame($urandom_range(256, 300), 1'b1, fill);
      end else if (pick < 40) begin
        send_frame(50, 1'b1, fill);
      end else if (pick < 50) begin
        send_frame(31, 1'b1, fill);
      end else if (pick < 62) begin
        send_frame($urandom_range(32, 49), 1'b1, fill);
      end else if (pick < 72) begin
        send_frame($urandom_range(51, 90), 1'b1, fill);
      end else if (pick < 86) begin
        send_frame($urandom_range(3, 60), 1'b0, fill);
      end else if (pick < 98) begin
        send_frame($urandom_range(1, 30), 1'($urandom_range(0, 1)), fill);
      end else begin
        send_frame($urandom_range(250, 260), 1'b1, fill);
      end
      frames++;
    end

    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/tfp_pkg.sv
src/tfp_core.sv
src/tfp_outq.sv
src/telemetry_frame_parser_crc_check_unit.sv
src/tfp_checker.sv
test/tb_telemetry_frame_parser_crc_check_unit_checker.sv
test/tb_telemetry_frame_parser_crc_check_unit.sv
